// ===== rtl/cubic_table_interpolator_assert.svh =====
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef CUBIC_TABLE_INTERPOLATOR_ASSERT_SVH
`define CUBIC_TABLE_INTERPOLATOR_ASSERT_SVH
// Implication, held off while reset is high.
`define CTI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, held off while reset is high.
`define CTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/cti_pkg.sv =====
// Package for the cubic table interpolator: widths, codes, states and helpers.
// No dependencies.
`timescale 1ns / 1ps
package cti_pkg;
  localparam int DefaultDepth = 4096;
  localparam int CountWidth   = 13;
  localparam int IndexWidth   = 12;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WAIT,
    S_EDGE_CHK,
    S_SRCH_RD,
    S_SRCH_WAIT,
    S_SRCH_CHK,
    S_PTS_RD,
    S_PTS_WAIT,
    S_PTS_CAP,
    S_STG_SETUP,
    S_STG_DIV,
    S_STG_MUL,
    S_STG_ADD,
    S_OUT
  } state_t;

  // divider handshake between the top level and the divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic [32:0] clip32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction
endpackage

// ===== rtl/cti_stream_if.sv =====
// Valid/ready channel interfaces for the cubic table interpolator.
// Depends on cti_pkg for field widths.
`timescale 1ns / 1ps
interface cti_in_if import cti_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [IndexWidth-1:0] entry_index;
  logic signed [31:0]    abscissa;
  logic signed [31:0]    ordinate;
  logic signed [31:0]    query_point;
  modport source (output valid, operation, entry_index, abscissa, ordinate, query_point,
                  input ready);
  modport sink (input valid, operation, entry_index, abscissa, ordinate, query_point,
                output ready);
endinterface

interface cti_out_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] interpolated_value;
  logic               out_of_range;
  logic               divide_error;
  logic               saturated;
  modport source (output valid, interpolated_value, out_of_range, divide_error, saturated,
                  input ready);
  modport sink (input valid, interpolated_value, out_of_range, divide_error, saturated,
                output ready);
endinterface

interface cti_cfg_if import cti_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/cti_divider.sv =====
// Restoring signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on cti_pkg for the control struct.
`timescale 1ns / 1ps
module cti_divider import cti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [32:0] divisor,
  output div_ctrl_t          ctrl,
  output logic signed [63:0] quotient
);
  logic [63:0] num;
  logic [63:0] rem;
  logic [32:0] den;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  assign trial = {rem[63:0], num[63]} - {32'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        num  <= dividend[63] ? 64'(-dividend) : dividend;
        den  <= divisor[32] ? 33'(-divisor) : divisor;
        neg  <= dividend[63] ^ divisor[32];
        rem  <= '0;
      end else if (busy) begin
        // shift in one dividend bit, keep the remainder if it fits
        if (!trial[64]) begin
          rem <= trial[63:0];
          num <= {num[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], num[63]};
          num <= {num[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient   = neg ? 64'(-num) : num;
  assign ctrl.start = start;
  assign ctrl.busy  = busy;
  assign ctrl.done  = done;
endmodule

// ===== rtl/cubic_table_interpolator.sv =====
// Cubic table interpolator: table memories, search sequencer and six-stage Neville evaluation.
// Depends on cti_pkg, cti_stream_if and cti_divider.
//
// Usage:
//   in_ch carries load items (operation 0) and query items (operation 1).
//   A load writes one table entry and returns nothing; the block stays idle, so
//   loads can follow back to back.
//   A query returns one result on out_ch: the value and the flags out_of_range,
//   divide_error and saturated.
//   cfg_ch writes point_count; write it only while the block is idle.
//   A query checks the table span and, if the point is in range, searches entry by
//   entry (one memory read port walks the table from index 2), fetches the four
//   points and runs up to 6 stages, each waiting on the bit-serial divider that
//   forms its slope. One item is in work at a time.
//   A result waits in the output register until taken; a stalled receiver holds
//   the block, and in_ch stays not ready until the result leaves.
//   Reset clears the control state and sets point_count to 4; table contents are
//   undefined until loaded. cfg_ch is always ready.
`timescale 1ns / 1ps
module cubic_table_interpolator import cti_pkg::*; #(
  parameter int TABLE_DEPTH = DefaultDepth
) (
  input logic   clk,
  input logic   rst,
  cti_in_if.sink    in_ch,
  cti_out_if.source out_ch,
  cti_cfg_if.sink   cfg_ch
);
  localparam int AW = $clog2(TABLE_DEPTH);

  logic signed [31:0] xmem [TABLE_DEPTH];
  logic signed [31:0] ymem [TABLE_DEPTH];
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] xrd;
  logic signed [31:0] yrd;

  logic [CountWidth-1:0] point_count;
  logic [CountWidth-1:0] n_eff;
  state_t state;
  state_t state_next;

  logic signed [31:0] p;
  logic [CountWidth-1:0] idx;
  logic [1:0]  step;
  logic [2:0]  stage;
  logic signed [31:0] px [4];
  logic signed [31:0] py [4];
  logic signed [31:0] vb;
  logic signed [31:0] vc;
  logic signed [31:0] vd;
  logic signed [31:0] c2;
  logic signed [31:0] d2;
  logic signed [31:0] ya;
  logic signed [31:0] yb;
  logic signed [31:0] xa;
  logic signed [31:0] xb;
  logic signed [31:0] slope;
  logic signed [63:0] prod;
  logic        sat;
  logic        oor;
  logic        derr;
  logic signed [31:0] result;

  logic               div_start;
  logic signed [63:0] div_num;
  logic signed [32:0] div_den;
  logic signed [63:0] div_q;
  div_ctrl_t          div_ctrl;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CountWidth'(4);
    end else if (cfg_ch.valid) begin
      point_count <= cfg_ch.data;
    end
  end

  always_comb begin
    if (point_count < CountWidth'(4)) begin
      n_eff = CountWidth'(4);
    end else if (32'(point_count) > TABLE_DEPTH) begin
      n_eff = CountWidth'(TABLE_DEPTH);
    end else begin
      n_eff = point_count;
    end
  end

  logic in_fire;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // table memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.operation == OP_LOAD &&
        32'(in_ch.entry_index) < TABLE_DEPTH) begin
      xmem[AW'(in_ch.entry_index)] <= in_ch.abscissa;
      ymem[AW'(in_ch.entry_index)] <= in_ch.ordinate;
    end
    xrd <= xmem[rd_addr];
    yrd <= ymem[rd_addr];
  end

  // hold the point address through the wait cycle so the capture sees it
  always_comb begin
    rd_addr = AW'(idx);
    if (state inside {S_PTS_RD, S_PTS_WAIT}) begin
      rd_addr = AW'(idx - CountWidth'(2) + CountWidth'(step));
    end
  end

  cti_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .ctrl     (div_ctrl),
    .quotient (div_q)
  );

  // operands of the current stage
  always_comb begin
    case (stage)
      3'd0: begin ya = py[1]; yb = py[0]; xa = px[1]; xb = px[0]; end
      3'd1: begin ya = py[2]; yb = py[0]; xa = px[2]; xb = px[0]; end
      3'd2: begin ya = py[3]; yb = py[0]; xa = px[3]; xb = px[0]; end
      3'd3: begin ya = vc;    yb = vb;    xa = px[2]; xb = px[1]; end
      3'd4: begin ya = vd;    yb = vb;    xa = px[3]; xb = px[1]; end
      default: begin ya = d2; yb = c2;    xa = px[3]; xb = px[2]; end
    endcase
  end

  logic signed [32:0] den_w;
  logic signed [32:0] dp_w;
  logic signed [63:0] fl_w;
  logic signed [63:0] sum_w;
  logic [32:0]        clip_s;
  logic [32:0]        clip_v;
  assign den_w  = 33'(xa) - 33'(xb);
  assign dp_w   = 33'(p) - 33'(xb);
  assign fl_w   = prod >>> 16;
  assign sum_w  = fl_w + 64'(yb);
  assign clip_s = clip32(div_q);
  assign clip_v = clip32(sum_w);
  assign div_num = (64'(ya) - 64'(yb)) <<< 16;
  assign div_den = den_w;
  assign div_start = (state == S_STG_SETUP) && (den_w != '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && in_ch.operation == OP_QUERY) state_next = S_EDGE_RD;
      end
      S_EDGE_RD:   state_next = S_EDGE_WAIT;
      S_EDGE_WAIT: state_next = S_EDGE_CHK;
      S_EDGE_CHK: begin
        if (step == 2'd0) begin
          state_next = (p <= xrd) ? S_OUT : S_EDGE_RD;
        end else begin
          state_next = (p > xrd) ? S_OUT : S_SRCH_RD;
        end
      end
      S_SRCH_RD:   state_next = S_SRCH_WAIT;
      S_SRCH_WAIT: state_next = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (idx < n_eff - CountWidth'(2) && p > xrd) state_next = S_SRCH_RD;
        else state_next = S_PTS_RD;
      end
      S_PTS_RD:    state_next = S_PTS_WAIT;
      S_PTS_WAIT:  state_next = S_PTS_CAP;
      S_PTS_CAP:   state_next = (step == 2'd3) ? S_STG_SETUP : S_PTS_RD;
      S_STG_SETUP: state_next = (den_w == '0) ? S_OUT : S_STG_DIV;
      S_STG_DIV:   state_next = div_ctrl.done ? S_STG_MUL : S_STG_DIV;
      S_STG_MUL:   state_next = S_STG_ADD;
      S_STG_ADD:   state_next = (stage == 3'd5) ? S_OUT : S_STG_SETUP;
      S_OUT:       state_next = out_ch.ready ? S_IDLE : S_OUT;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        p      <= in_ch.query_point;
        idx    <= CountWidth'(1);
        step   <= 2'd0;
        stage  <= 3'd0;
        sat    <= 1'b0;
        oor    <= 1'b0;
        derr   <= 1'b0;
        result <= '0;
      end
      S_EDGE_CHK: begin
        if (step == 2'd0) begin
          if (p <= xrd) oor <= 1'b1;
          idx  <= n_eff - CountWidth'(2);
          step <= 2'd1;
        end else begin
          if (p > xrd) oor <= 1'b1;
          idx  <= CountWidth'(2);
          step <= 2'd0;
        end
      end
      S_SRCH_CHK: begin
        if (idx < n_eff - CountWidth'(2) && p > xrd) idx <= idx + CountWidth'(1);
      end
      S_PTS_CAP: begin
        px[step] <= xrd;
        py[step] <= yrd;
        step     <= step + 2'd1;
      end
      S_STG_SETUP: begin
        if (den_w == '0) begin
          derr <= 1'b1;
          sat  <= 1'b0;
        end
      end
      S_STG_DIV: begin
        if (div_ctrl.done) begin
          slope <= clip_s[31:0];
          if (clip_s[32]) sat <= 1'b1;
        end
      end
      S_STG_MUL: prod <= 64'(slope) * 64'(dp_w);
      S_STG_ADD: begin
        if (clip_v[32]) sat <= 1'b1;
        case (stage)
          3'd0: vb <= clip_v[31:0];
          3'd1: vc <= clip_v[31:0];
          3'd2: vd <= clip_v[31:0];
          3'd3: c2 <= clip_v[31:0];
          3'd4: d2 <= clip_v[31:0];
          default: result <= clip_v[31:0];
        endcase
        stage <= stage + 3'd1;
      end
      default: ;
    endcase
  end

  assign out_ch.valid              = (state == S_OUT);
  assign out_ch.interpolated_value = (oor || derr) ? 32'sd0 : result;
  assign out_ch.out_of_range       = oor;
  assign out_ch.divide_error       = derr && !oor;
  assign out_ch.saturated          = sat && !oor && !derr;
endmodule

// ===== rtl/cti_checker.sv =====
// Port-level checker for the cubic table interpolator, bound to the top level.
// Depends on cubic_table_interpolator_assert.svh.
`timescale 1ns / 1ps
`include "cubic_table_interpolator_assert.svh"
module cti_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_oor,
  input logic        out_derr,
  input logic        out_sat
);
  `CTI_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready, "input taken while a result is pending")
  `CTI_ASSERT_IMPL(a_zero_flag, out_valid && (out_oor || out_derr), out_value == 32'd0,
                   "flagged result is not zero")
  `CTI_ASSERT_IMPL(a_one_flag, out_valid, $countones({out_oor, out_derr, out_sat}) <= 1,
                   "more than one flag raised")
  `CTI_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && !in_op, !out_valid,
                   "load produced a result")
  `CTI_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(out_value),
                   "stalled result changed or dropped")
endmodule

bind cubic_table_interpolator cti_checker u_cti_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.operation),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.interpolated_value),
  .out_oor   (out_ch.out_of_range),
  .out_derr  (out_ch.divide_error),
  .out_sat   (out_ch.saturated)
);
